### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// clocked assertion, checked in every cycle
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### src/fbsc_pkg.sv
// ----------------------------------------------------------------------------
// fbsc_pkg
// Types and constants of the frustum box and sphere cull unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbsc_pkg;

    localparam int NUM_PLANES = 4;
    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 16;
    localparam int CORNER_W   = COORD_W + 1;
    localparam int NORMAL_W   = 16;
    localparam int DIST_W     = 32;
    localparam int PROD_W     = CORNER_W + NORMAL_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int CMP_W      = DOT_W + 2;
    localparam int FRAC_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = NUM_AXES * NORMAL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_BASE = 3'd4;

    localparam logic MODE_BOX    = 1'b0;
    localparam logic MODE_SPHERE = 1'b1;

    typedef struct packed {
        logic                               mode;
        logic [NUM_AXES-1:0][CORNER_W-1:0]  org;
        logic [NUM_AXES-1:0][CORNER_W-1:0]  lo;
        logic [NUM_AXES-1:0][CORNER_W-1:0]  hi;
        logic [COORD_W-1:0]                 radius;
        logic                               culled;
    } t_obj;

endpackage

### src/frustum_box_sphere_cull_unit.sv
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull_unit
// Frustum cull of boxes and spheres against up to four planes, one plane
// cell per stage pair in a chain.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  object    | i_start, o_busy, i_mode, i_origin_*,      | in
//            | i_box_lo_*, i_box_hi_*, i_sphere_radius   |
//  result    | o_done, o_culled                          | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | in
//            | i_cfg_data                                |
//
//  One object beat per cycle; o_busy stays low.
//  Each object passes one input register, then per plane cell a product
//  register and a compare register (cells = min(PLANE_COUNT, 4)).
//  Synchronous active-low reset clears all valid flags and plane registers.
//  Results are strobed for one cycle on o_done and cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_box_sphere_cull_unit
    import fbsc_pkg::*;
#(
    parameter int PLANE_COUNT = 4
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_mode,
    input  logic signed [15:0]    i_origin_x,
    input  logic signed [15:0]    i_origin_y,
    input  logic signed [15:0]    i_origin_z,
    input  logic signed [15:0]    i_box_lo_x,
    input  logic signed [15:0]    i_box_lo_y,
    input  logic signed [15:0]    i_box_lo_z,
    input  logic signed [15:0]    i_box_hi_x,
    input  logic signed [15:0]    i_box_hi_y,
    input  logic signed [15:0]    i_box_hi_z,
    input  logic [15:0]           i_sphere_radius,
    output logic                  o_done,
    output logic                  o_culled,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CELLS = (PLANE_COUNT > NUM_PLANES) ? NUM_PLANES : PLANE_COUNT;

    logic [CFG_DATA_W-1:0] r_normal [NUM_PLANES];
    logic [DIST_W-1:0]     r_dist   [NUM_PLANES];

    logic                  r_in_valid;
    t_obj                  r_in_obj;
    t_obj                  n_in_obj;
    logic [COORD_W-1:0]    n_org [NUM_AXES];
    logic [COORD_W-1:0]    n_lo  [NUM_AXES];
    logic [COORD_W-1:0]    n_hi  [NUM_AXES];

    logic                  w_valid [CELLS+1];
    t_obj                  w_obj   [CELLS+1];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_normal[p] <= '0;
                r_dist[p]   <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index < CFG_DIST_BASE) begin
                r_normal[i_cfg_index[1:0]] <= i_cfg_data;
            end else begin
                r_dist[i_cfg_index[1:0]] <= i_cfg_data[DIST_W-1:0];
            end
        end
    end

    always_comb begin
        n_org[0] = i_origin_x;
        n_org[1] = i_origin_y;
        n_org[2] = i_origin_z;
        n_lo[0]  = i_box_lo_x;
        n_lo[1]  = i_box_lo_y;
        n_lo[2]  = i_box_lo_z;
        n_hi[0]  = i_box_hi_x;
        n_hi[1]  = i_box_hi_y;
        n_hi[2]  = i_box_hi_z;
        n_in_obj.mode   = i_mode;
        n_in_obj.radius = i_sphere_radius;
        n_in_obj.culled = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_in_obj.org[a] = {n_org[a][COORD_W-1], n_org[a]};
            n_in_obj.lo[a]  = {n_org[a][COORD_W-1], n_org[a]}
                            + {n_lo[a][COORD_W-1], n_lo[a]};
            n_in_obj.hi[a]  = {n_org[a][COORD_W-1], n_org[a]}
                            + {n_hi[a][COORD_W-1], n_hi[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start;
        end
        r_in_obj <= n_in_obj;
    end

    assign w_valid[0] = r_in_valid;
    assign w_obj[0]   = r_in_obj;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        fbsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[k]),
            .i_obj    (w_obj[k]),
            .i_normal (r_normal[k]),
            .i_dist   (r_dist[k]),
            .o_valid  (w_valid[k+1]),
            .o_obj    (w_obj[k+1])
        );
    end

    assign o_done   = w_valid[CELLS];
    assign o_culled = w_obj[CELLS].culled;

endmodule

### src/fbsc_cell.sv
// ----------------------------------------------------------------------------
// fbsc_cell
// One plane of the cull chain: corner select (centre for spheres) and products,
// then dot sum and plane compare, passing the object on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbsc_cell
    import fbsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_obj                  i_obj,
    input  logic [CFG_DATA_W-1:0] i_normal,
    input  logic [DIST_W-1:0]     i_dist,
    output logic                  o_valid,
    output t_obj                  o_obj
);

    logic                           r_s1_valid;
    t_obj                           r_s1_obj;
    logic signed [PROD_W-1:0]       r_prod [NUM_AXES];
    logic signed [PROD_W-1:0]       n_prod [NUM_AXES];
    logic signed [NORMAL_W-1:0]     n_comp [NUM_AXES];
    logic signed [CORNER_W-1:0]     n_coord [NUM_AXES];

    logic                           r_out_valid;
    t_obj                           r_out_obj;
    t_obj                           n_out_obj;
    logic signed [DOT_W-1:0]        n_dot;
    logic signed [CMP_W-1:0]        n_lhs;
    logic signed [CMP_W-1:0]        n_rhs;
    logic                           n_hit;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_comp[a] = i_normal[a*NORMAL_W +: NORMAL_W];
            if (i_obj.mode == MODE_SPHERE) begin
                n_coord[a] = i_obj.org[a];
            end else if (n_comp[a][NORMAL_W-1]) begin
                n_coord[a] = i_obj.lo[a];
            end else begin
                n_coord[a] = i_obj.hi[a];
            end
            n_prod[a] = n_coord[a] * n_comp[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_obj <= i_obj;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_prod[a] <= n_prod[a];
        end
    end

    always_comb begin
        n_dot = {{2{r_prod[0][PROD_W-1]}}, r_prod[0]}
              + {{2{r_prod[1][PROD_W-1]}}, r_prod[1]}
              + {{2{r_prod[2][PROD_W-1]}}, r_prod[2]};
        n_rhs = {{(CMP_W-DIST_W){i_dist[DIST_W-1]}}, i_dist};
        if (r_s1_obj.mode == MODE_SPHERE) begin
            n_lhs = {{2{n_dot[DOT_W-1]}}, n_dot}
                  + {{(CMP_W-COORD_W-FRAC_W){1'b0}}, r_s1_obj.radius, {FRAC_W{1'b0}}};
            n_hit = (n_lhs <= n_rhs);
        end else begin
            n_lhs = {{2{n_dot[DOT_W-1]}}, n_dot};
            n_hit = (n_lhs < n_rhs);
        end
        n_out_obj        = r_s1_obj;
        n_out_obj.culled = r_s1_obj.culled | n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
        r_out_obj <= n_out_obj;
    end

    assign o_valid = r_out_valid;
    assign o_obj   = r_out_obj;

endmodule

### src/fbsc_checker.sv
// ----------------------------------------------------------------------------
// fbsc_checker
// Port-level checks of the cull unit: fixed latency and steady ready flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbsc_checker
    import fbsc_pkg::*;
#(
    parameter int PLANE_COUNT = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic o_busy,
    input  logic o_done,
    input  logic o_cfg_ready
);

    localparam int CELLS = (PLANE_COUNT > NUM_PLANES) ? NUM_PLANES : PLANE_COUNT;
    localparam int LAT   = 1 + 2 * CELLS;

    `ASSERT_RST(a_done_after_beat, i_clk, i_rst_n, (i_start && !o_busy) |-> ##LAT o_done)
    `ASSERT_RST(a_no_stray_done, i_clk, i_rst_n, !(i_start && !o_busy) |-> ##LAT !o_done)
    `ASSERT_ALWAYS(a_never_busy, i_clk, !o_busy)
    `ASSERT_ALWAYS(a_cfg_ready, i_clk, o_cfg_ready)

endmodule

bind frustum_box_sphere_cull_unit fbsc_checker #(
    .PLANE_COUNT (PLANE_COUNT)
) u_fbsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_cfg_ready (o_cfg_ready)
);
